// ===== rtl/pts_pkg.sv =====
// Shared types and constants of the priority task scheduler.
`default_nettype none

package pts_pkg;

	localparam int IDX_W = 4;
	localparam int PRI_W = 7;
	localparam int DLY_W = 32;
	localparam int ACT_W = 3;

	// Task states held in the state table.
	localparam logic [1:0] ST_READY     = 2'd0;
	localparam logic [1:0] ST_RUNNING   = 2'd1;
	localparam logic [1:0] ST_WAITING   = 2'd2;
	localparam logic [1:0] ST_SUSPENDED = 2'd3;

	// Event codes.
	localparam logic [ACT_W-1:0] ACT_CREATE   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DELAY    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SUSPEND  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ACTIVATE = 3'd4;
	localparam logic [ACT_W-1:0] ACT_TICK     = 3'd5;

	// Operations of the shared subtract unit.
	localparam logic ALU_SUB = 1'b0;
	localparam logic ALU_DEC = 1'b1;

	typedef struct packed {
		logic              pri_we;
		logic              st_we;
		logic              dly_we;
		logic [IDX_W-1:0]  addr;
		logic [PRI_W-1:0]  pri;
		logic [1:0]        st;
		logic [DLY_W-1:0]  dly;
	} tbl_wr_t;

	typedef struct packed {
		logic [PRI_W-1:0]  pri;
		logic [1:0]        st;
		logic [DLY_W-1:0]  dly;
	} tbl_rd_t;

	typedef struct packed {
		logic [DLY_W-1:0]  diff;
		logic              borrow;
		logic              zero;
	} alu_res_t;

endpackage

`default_nettype wire

// ===== rtl/pts_alu.sv =====
// Shared subtract unit: decrements a delay counter or compares two priorities.
`default_nettype none

module pts_alu (
	input  wire logic                      op,
	input  wire logic [pts_pkg::DLY_W-1:0] a,
	input  wire logic [pts_pkg::DLY_W-1:0] b,
	output pts_pkg::alu_res_t              res
);
	import pts_pkg::*;

	logic [DLY_W-1:0] rhs;
	logic [DLY_W:0]   wide;

	always_comb begin
		rhs = (op == ALU_DEC) ? DLY_W'(1) : b;
		wide = {1'b0, a} - {1'b0, rhs};
		res.diff = wide[DLY_W-1:0];
		res.borrow = wide[DLY_W];
		res.zero = (wide[DLY_W-1:0] == '0);
	end

endmodule

`default_nettype wire

// ===== rtl/pts_table.sv =====
// Task table: priority, state and delay of every slot, one write and one read port.
`default_nettype none

module pts_table #(
	parameter int SLOTS = 9
) (
	input  wire logic                      clk,
	input  wire pts_pkg::tbl_wr_t          wr,
	input  wire logic [pts_pkg::IDX_W-1:0] rd_addr,
	output pts_pkg::tbl_rd_t               rd
);
	import pts_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [PRI_W-1:0] pri_mem [SLOTS];
	logic [1:0]       st_mem  [SLOTS];
	logic [DLY_W-1:0] dly_mem [SLOTS];

	// Entries have no reset; only slots below the task count ever affect a result.
	always_ff @(posedge clk) begin
		if (wr.pri_we) begin
			pri_mem[wr.addr[AW-1:0]] <= wr.pri;
		end
		if (wr.st_we) begin
			st_mem[wr.addr[AW-1:0]] <= wr.st;
		end
		if (wr.dly_we) begin
			dly_mem[wr.addr[AW-1:0]] <= wr.dly;
		end
	end

	always_comb begin
		rd.pri = pri_mem[rd_addr[AW-1:0]];
		rd.st = st_mem[rd_addr[AW-1:0]];
		rd.dly = dly_mem[rd_addr[AW-1:0]];
	end

endmodule

`default_nettype wire

// ===== rtl/priority_task_scheduler_top.sv =====
// Top level of the priority task scheduler: event sequencer, table and shared unit.
//
// channel  direction  handshake                  payload
// item     in         item_valid / item_ready    action, task_priority, start_suspended,
//                                                delay_ticks, target_task
// result   out        result_valid / result_ready created_index, create_failed,
//                                                selected_task, task_switched
//
// A tick beat runs from acceptance to result_valid through these steps, N being the task count
// (at most MAX_TASKS + 1): the event step applies the event, the tick sweep and the selection
// sweep each visit N slots and an end check through the shared subtract unit, and the done
// step loads the result register. Other events skip the tick sweep.
// item_ready is high only while the sequencer is idle and rises with result_valid; a result
// waiting on result_ready holds the sequencer in its final step. Reset empties the table.
`default_nettype none

module priority_task_scheduler_top #(
	parameter int MAX_TASKS = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	output logic                           item_ready,
	input  wire logic [pts_pkg::ACT_W-1:0] action,
	input  wire logic [pts_pkg::PRI_W-1:0] task_priority,
	input  wire logic                      start_suspended,
	input  wire logic [pts_pkg::DLY_W-1:0] delay_ticks,
	input  wire logic [pts_pkg::IDX_W-1:0] target_task,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output logic [pts_pkg::IDX_W-1:0]      created_index,
	output logic                           create_failed,
	output logic [pts_pkg::IDX_W-1:0]      selected_task,
	output logic                           task_switched
);
	import pts_pkg::*;

	localparam int SLOTS = MAX_TASKS + 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVENT = 3'd1;
	localparam logic [2:0] S_TICK  = 3'd2;
	localparam logic [2:0] S_PICK  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [ACT_W-1:0] action_q;
	logic [PRI_W-1:0] pri_q;
	logic             susp_q;
	logic [DLY_W-1:0] ticks_q;
	logic [IDX_W-1:0] target_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] running_q;
	logic [CNT_W-1:0] idx_q;
	logic             found_q;
	logic [PRI_W-1:0] best_pri_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [IDX_W-1:0] created_q;
	logic             failed_q;
	logic [IDX_W-1:0] next_q;

	logic             result_valid_q;
	logic [IDX_W-1:0] created_index_q;
	logic             create_failed_q;
	logic [IDX_W-1:0] selected_task_q;
	logic             task_switched_q;

	tbl_wr_t          wr;
	tbl_rd_t          rd;
	logic [IDX_W-1:0] rd_addr;
	logic             alu_op;
	logic [DLY_W-1:0] alu_a;
	logic [DLY_W-1:0] alu_b;
	alu_res_t         alu_res;

	logic             sweep_end;
	logic             create_ok;
	logic             eligible;
	logic [IDX_W-1:0] pick_result;

	pts_table #(
		.SLOTS(SLOTS)
	) u_table (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd      (rd)
	);

	pts_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	assign item_ready = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign created_index = created_index_q;
	assign create_failed = create_failed_q;
	assign selected_task = selected_task_q;
	assign task_switched = task_switched_q;

	always_comb begin
		sweep_end = (idx_q == count_q);
		rd_addr = IDX_W'(idx_q);
		eligible = (rd.st == ST_READY) || (rd.st == ST_RUNNING);
		if (action_q == ACT_CREATE) begin
			create_ok = (count_q < CNT_W'(MAX_TASKS));
		end else begin
			create_ok = (count_q < CNT_W'(SLOTS));
		end
		if (count_q == '0) begin
			pick_result = '0;
		end else if (found_q) begin
			pick_result = best_idx_q;
		end else begin
			pick_result = IDX_W'(count_q - 1'b1);
		end

		alu_op = (state_q == S_TICK) ? ALU_DEC : ALU_SUB;
		alu_a = (state_q == S_TICK) ? rd.dly : DLY_W'(best_pri_q);
		alu_b = DLY_W'(rd.pri);

		wr = '0;
		case (state_q)
			S_EVENT: begin
				case (action_q)
					ACT_CREATE, ACT_START: begin
						wr.addr = IDX_W'(count_q);
						wr.pri = (action_q == ACT_CREATE) ? pri_q : '0;
						wr.st = (action_q == ACT_CREATE && susp_q) ? ST_SUSPENDED : ST_READY;
						wr.dly = '0;
						wr.pri_we = create_ok;
						wr.st_we = create_ok;
						wr.dly_we = create_ok;
					end
					ACT_DELAY: begin
						wr.addr = running_q;
						wr.st = ST_WAITING;
						wr.dly = ticks_q;
						wr.st_we = 1'b1;
						wr.dly_we = 1'b1;
					end
					ACT_SUSPEND: begin
						wr.addr = running_q;
						wr.st = ST_SUSPENDED;
						wr.st_we = 1'b1;
					end
					ACT_ACTIVATE: begin
						wr.addr = target_q;
						wr.st = ST_READY;
						wr.st_we = ({1'b0, target_q} < (IDX_W + 1)'(count_q));
					end
					default: begin
					end
				endcase
			end
			S_TICK: begin
				// A waiting task counts down and wakes when its counter reaches zero.
				wr.addr = IDX_W'(idx_q);
				wr.dly = alu_res.diff;
				wr.st = ST_READY;
				wr.dly_we = !sweep_end && (rd.st == ST_WAITING);
				wr.st_we = !sweep_end && (rd.st == ST_WAITING) && alu_res.zero;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			running_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_EVENT;
					end
				end
				S_EVENT: begin
					if ((action_q == ACT_CREATE || action_q == ACT_START) && create_ok) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= (action_q == ACT_TICK) ? S_TICK : S_PICK;
				end
				S_TICK: begin
					if (sweep_end) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (sweep_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!result_valid_q || result_ready) begin
						running_q <= next_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_DONE && (!result_valid_q || result_ready)) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				action_q <= action;
				pri_q <= task_priority;
				susp_q <= start_suspended;
				ticks_q <= delay_ticks;
				target_q <= target_task;
				idx_q <= '0;
				found_q <= 1'b0;
			end
			S_EVENT: begin
				created_q <= '0;
				failed_q <= 1'b0;
				if (action_q == ACT_CREATE || action_q == ACT_START) begin
					created_q <= create_ok ? IDX_W'(count_q) : '0;
					failed_q <= !create_ok;
				end
			end
			S_TICK: begin
				idx_q <= sweep_end ? '0 : idx_q + 1'b1;
			end
			S_PICK: begin
				if (sweep_end) begin
					next_q <= pick_result;
				end else begin
					idx_q <= idx_q + 1'b1;
					// The borrow of best minus this priority means this one is strictly higher.
					if (eligible && (!found_q || alu_res.borrow)) begin
						found_q <= 1'b1;
						best_pri_q <= rd.pri;
						best_idx_q <= IDX_W'(idx_q);
					end
				end
			end
			S_DONE: begin
				if (!result_valid_q || result_ready) begin
					created_index_q <= created_q;
					create_failed_q <= failed_q;
					selected_task_q <= next_q;
					task_switched_q <= (next_q != running_q);
				end
			end
			default: begin
			end
		endcase
	end

	a_running_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, running_q} < (IDX_W + 1)'(SLOTS))
		else $error("running task index beyond the table");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= $past(count_q)) && (count_q <= CNT_W'(SLOTS)))
		else $error("task count shrank or overflowed");

	a_failed_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && create_failed_q |-> created_index_q == '0)
		else $error("refused create reports a nonzero index");

	a_select_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (selected_task_q == '0) ||
			({1'b0, selected_task_q} < (IDX_W + 1)'(count_q)))
		else $error("selected task is not in the table");

endmodule

`default_nettype wire

// ===== test/tb_priority_task_scheduler_top.sv =====
// Testbench for the priority task scheduler: directed and random event stream checked against a dispatch model.
`timescale 1ns / 1ps

module tb_priority_task_scheduler_top;
	import pts_pkg::*;

	localparam int MAX_TASKS  = 8;
	localparam int SLOT_N     = MAX_TASKS + 1;
	localparam int RAND_ITEMS = 2000;
	localparam int DRAIN_CYCLES = 4 * SLOT_N + 20;
	localparam int HOLD_CYCLES  = 400;

	localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [PRI_W-1:0] pri;
		logic             susp;
		logic [DLY_W-1:0] ticks;
		logic [IDX_W-1:0] target;
	} sched_event_t;

	typedef struct packed {
		logic [IDX_W-1:0] created;
		logic             failed;
		logic [IDX_W-1:0] sel;
		logic             switched;
	} dispatch_t;

	class dispatch_tracker;
		int unsigned      task_count;
		int unsigned      cur_index;
		logic [PRI_W-1:0] pri_tab [SLOT_N];
		logic [1:0]       st_tab  [SLOT_N];
		logic [DLY_W-1:0] dly_tab [SLOT_N];
		dispatch_t        expected_dispatch [$];
		int               errors;

		function new();
			task_count = 0;
			cur_index  = 0;
			errors     = 0;
			foreach (pri_tab[i]) begin
				pri_tab[i] = '0;
				st_tab[i]  = ST_READY;
				dly_tab[i] = '0;
			end
		endfunction

		function bit append_slot(int unsigned limit, logic [PRI_W-1:0] pri, logic [1:0] st,
				output logic [IDX_W-1:0] idx);
			idx = '0;
			if (task_count >= limit)
				return 1'b0;
			pri_tab[task_count] = pri;
			st_tab[task_count]  = st;
			dly_tab[task_count] = '0;
			idx = task_count[IDX_W-1:0];
			task_count++;
			return 1'b1;
		endfunction

		// Highest priority among ready or running tasks, lowest index on a tie;
		// the last created task when nothing is eligible.
		function int unsigned pick_next();
			int          best_pri;
			int unsigned best_idx;
			if (task_count == 0)
				return 0;
			best_pri = -1;
			best_idx = task_count - 1;
			for (int unsigned i = 0; i < task_count; i++) begin
				if ((st_tab[i] == ST_READY || st_tab[i] == ST_RUNNING) &&
						int'(pri_tab[i]) > best_pri) begin
					best_pri = int'(pri_tab[i]);
					best_idx = i;
				end
			end
			return best_idx;
		endfunction

		function void note_event(sched_event_t ev);
			dispatch_t        d;
			int unsigned      nxt;
			logic [IDX_W-1:0] idx;
			d = '0;
			case (ev.act)
				ACT_CREATE: begin
					if (append_slot(MAX_TASKS, ev.pri, ev.susp ? ST_SUSPENDED : ST_READY, idx))
						d.created = idx;
					else
						d.failed = 1'b1;
				end
				ACT_START: begin
					if (append_slot(SLOT_N, '0, ST_READY, idx))
						d.created = idx;
					else
						d.failed = 1'b1;
				end
				ACT_DELAY: begin
					st_tab[cur_index]  = ST_WAITING;
					dly_tab[cur_index] = ev.ticks;
				end
				ACT_SUSPEND: begin
					st_tab[cur_index] = ST_SUSPENDED;
				end
				ACT_ACTIVATE: begin
					if (ev.target < task_count)
						st_tab[ev.target] = ST_READY;
				end
				ACT_TICK: begin
					for (int unsigned i = 0; i < task_count; i++) begin
						if (st_tab[i] == ST_WAITING) begin
							dly_tab[i] = dly_tab[i] - 1'b1;
							if (dly_tab[i] == '0)
								st_tab[i] = ST_READY;
						end
					end
				end
				default: begin
				end
			endcase
			nxt        = pick_next();
			d.sel      = nxt[IDX_W-1:0];
			d.switched = (nxt != cur_index);
			cur_index  = nxt;
			expected_dispatch.push_back(d);
		endfunction

		function void report(string what, logic [DLY_W-1:0] want, logic [DLY_W-1:0] got);
			errors++;
			if (errors <= 100)
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		endfunction

		function void check_dispatch(dispatch_t got);
			dispatch_t want;
			if (expected_dispatch.size() == 0) begin
				errors++;
				if (errors <= 100)
					$display("%0t: result beat with nothing expected, selected %0d",
						$time, got.sel);
				return;
			end
			want = expected_dispatch.pop_front();
			if (got.created !== want.created)
				report("created_index", want.created, got.created);
			if (got.failed !== want.failed)
				report("create_failed", want.failed, got.failed);
			if (got.sel !== want.sel)
				report("selected_task", want.sel, got.sel);
			if (got.switched !== want.switched)
				report("task_switched", want.switched, got.switched);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	logic [ACT_W-1:0] action;
	logic [PRI_W-1:0] task_priority;
	logic             start_suspended;
	logic [DLY_W-1:0] delay_ticks;
	logic [IDX_W-1:0] target_task;
	logic             result_valid;
	logic             result_ready;
	logic [IDX_W-1:0] created_index;
	logic             create_failed;
	logic [IDX_W-1:0] selected_task;
	logic             task_switched;

	dispatch_tracker tracker = new();
	int unsigned     dispatch_seen = 0;

	priority_task_scheduler_top #(
		.MAX_TASKS(MAX_TASKS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.action         (action),
		.task_priority  (task_priority),
		.start_suspended(start_suspended),
		.delay_ticks    (delay_ticks),
		.target_task    (target_task),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.created_index  (created_index),
		.create_failed  (create_failed),
		.selected_task  (selected_task),
		.task_switched  (task_switched)
	);

	always #5 clk = ~clk;

	// Both channels are sampled at the edge, before any driver update lands.
	always @(posedge clk) begin
		if (item_valid && item_ready)
			tracker.note_event('{action, task_priority, start_suspended, delay_ticks,
				target_task});
		if (result_valid && result_ready) begin
			tracker.check_dispatch('{created_index, create_failed, selected_task,
				task_switched});
			dispatch_seen++;
		end
	end

	function automatic sched_event_t mk_event(logic [ACT_W-1:0] act, logic [PRI_W-1:0] pri,
			logic susp, logic [DLY_W-1:0] ticks, logic [IDX_W-1:0] target);
		sched_event_t ev;
		ev = '{act, pri, susp, ticks, target};
		return ev;
	endfunction

	function automatic sched_event_t random_event();
		sched_event_t ev;
		int unsigned  r;
		ev.pri  = PRI_W'($urandom);
		ev.susp = 1'($urandom);
		r = $urandom_range(0, 99);
		if (r < 4)
			ev.act = ACT_CREATE;
		else if (r < 7)
			ev.act = ACT_START;
		else if (r < 27)
			ev.act = ACT_DELAY;
		else if (r < 37)
			ev.act = ACT_SUSPEND;
		else if (r < 62)
			ev.act = ACT_ACTIVATE;
		else if (r < 97)
			ev.act = ACT_TICK;
		else
			ev.act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
		// Mostly short delays so that ticks bring tasks back to ready.
		r = $urandom_range(0, 99);
		if (r < 70)
			ev.ticks = $urandom_range(1, 6);
		else if (r < 75)
			ev.ticks = '0;
		else if (r < 80)
			ev.ticks = '1;
		else
			ev.ticks = $urandom;
		ev.target = IDX_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, SLOT_N - 1) :
			$urandom_range(0, 15));
		return ev;
	endfunction

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic drive_item(sched_event_t ev);
		item_valid      <= 1'b1;
		action          <= ev.act;
		task_priority   <= ev.pri;
		start_suspended <= ev.susp;
		delay_ticks     <= ev.ticks;
		target_task     <= ev.target;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	initial begin
		sched_event_t directed [$];
		sched_event_t ev;
		int unsigned  sent;
		int unsigned  total;
		int unsigned  burst;
		int unsigned  gap;

		arst_n          <= 1'b0;
		item_valid      <= 1'b0;
		action          <= ACT_TICK;
		task_priority   <= '0;
		start_suspended <= 1'b0;
		delay_ticks     <= '0;
		target_task     <= '0;

		// Events on the empty table act on slot zero or change nothing.
		directed.push_back(mk_event(ACT_SUSPEND, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_DELAY, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_TICK, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_ACTIVATE, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_SPARE_A, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_SPARE_B, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_CREATE, 127, 0, 0, 0));
		directed.push_back(mk_event(ACT_CREATE, 0, 1, 0, 0));
		directed.push_back(mk_event(ACT_CREATE, 127, 0, 0, 0));
		directed.push_back(mk_event(ACT_START, 0, 0, 0, 0));
		// A zero delay wraps, so task zero waits practically forever.
		directed.push_back(mk_event(ACT_DELAY, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_DELAY, 0, 0, 1, 0));
		directed.push_back(mk_event(ACT_TICK, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_SUSPEND, 0, 0, 0, 0));
		// Nothing eligible after this one: the last created task is chosen.
		directed.push_back(mk_event(ACT_SUSPEND, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_ACTIVATE, 0, 0, 0, 15));
		directed.push_back(mk_event(ACT_ACTIVATE, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_DELAY, 0, 0, '1, 0));
		repeat (4)
			directed.push_back(mk_event(ACT_CREATE, PRI_W'($urandom), 1'($urandom), 0, 0));
		// Table holds eight tasks: create is refused, start fills the idle slot once.
		directed.push_back(mk_event(ACT_CREATE, 127, 0, 0, 0));
		directed.push_back(mk_event(ACT_START, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_START, 0, 0, 0, 0));
		directed.push_back(mk_event(ACT_ACTIVATE, 0, 0, 0, 1));

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		total = directed.size() + RAND_ITEMS;
		sent  = 0;
		while (sent < total) begin
			burst = $urandom_range(1, 8);
			for (int unsigned k = 0; k < burst && sent < total; k++) begin
				ev = (sent < directed.size()) ? directed[sent] : random_event();
				drive_item(ev);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
		end
		item_valid <= 1'b0;

		while (tracker.expected_dispatch.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (tracker.errors == 0 && tracker.expected_dispatch.size() == 0)
			$display("priority_task_scheduler_top: match");
		else
			$display("priority_task_scheduler_top: mismatch");
		$finish;
	end

	// Receiver: stretches of steady, random and sparse ready, plus one long hold-off
	// that backs the block up into its input.
	initial begin
		int unsigned mode;
		int unsigned len;
		bit          held;
		held = 1'b0;
		result_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held && dispatch_seen >= 150) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end
			mode = $urandom_range(0, 2);
			len  = $urandom_range(10, 60);
			repeat (len) begin
				case (mode)
					0: result_ready <= 1'b1;
					1: result_ready <= 1'($urandom_range(0, 1));
					default: result_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		#(8_000_000);
		$display("priority_task_scheduler_top: mismatch");
		$finish;
	end

endmodule
